@@ rtl/wpm_pkg.sv @@
`default_nettype none
package wpm_pkg;

  // Request commands
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_STRING = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  localparam logic [15:0] CODE_STAR    = 16'h002A;
  localparam logic [15:0] CODE_QMARK   = 16'h003F;
  localparam logic [15:0] CODE_UPPER_A = 16'h0041;
  localparam logic [15:0] CODE_UPPER_Z = 16'h005A;
  localparam logic [15:0] CASE_OFFSET  = 16'h0020;

  // APB register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_IGNORE_CASE = 1'b0;  // index taken from paddr[2]

  typedef struct packed {
    cmd_e        command;
    logic [15:0] char_code;
  } req_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } rsp_t;

  // Pattern store control
  typedef struct packed {
    logic        clear;
    logic        append;   // append of a nonzero code
    logic [15:0] code;
  } pat_ctl_t;

  // NFA step control
  typedef struct packed {
    logic str_step;   // nonzero string char
    logic rearm;      // back to bit zero only
  } nfa_ctl_t;

  function automatic logic [15:0] fold(input logic [15:0] c, input logic ic);
    if (ic && (c >= CODE_UPPER_A) && (c <= CODE_UPPER_Z)) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wpm_if.sv @@
`default_nettype none
interface wpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] char_code;
  modport source(output valid, command, char_code, input ready);
  modport sink(input valid, command, char_code, output ready);
endinterface

interface wpm_rsp_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  modport source(output valid, matched, pattern_overflow, input ready);
  modport sink(input valid, matched, pattern_overflow, output ready);
endinterface
`default_nettype wire

@@ rtl/wpm_apb_regs.sv @@
`default_nettype none
module wpm_apb_regs
  import wpm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic                   ignore_case_o
);

  logic ignore_case_q, ignore_case_d;
  logic sel_ic;

  assign sel_ic = (paddr[2] == REG_IGNORE_CASE);
  assign pready = 1'b1;

  always_comb begin
    ignore_case_d = ignore_case_q;
    if (psel && penable && pwrite && sel_ic) begin
      ignore_case_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_case_q <= 1'b0;
    end else begin
      ignore_case_q <= ignore_case_d;
    end
  end

  assign prdata        = sel_ic ? {{(APB_DW-1){1'b0}}, ignore_case_q} : '0;
  assign ignore_case_o = ignore_case_q;

endmodule
`default_nettype wire

@@ rtl/wpm_pattern_store.sv @@
`default_nettype none
module wpm_pattern_store
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LW = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pat_ctl_t               ctl_i,
  input  wire logic [15:0]            str_code_i,
  input  wire logic                   ignore_case_i,
  output logic      [LW-1:0]          len_o,
  output logic                        full_o,
  output logic                        overflow_o,
  output logic      [PATTERN_MAX-1:0] star_mask_o,
  output logic      [PATTERN_MAX-1:0] hit_mask_o
);

  localparam int unsigned IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [15:0]   pat_q [PATTERN_MAX];
  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic          full;
  logic [15:0]   str_fold;

  assign full = (len_q == LW'(PATTERN_MAX));

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (ctl_i.clear) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else if (ctl_i.append) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  // Store entries: no reset, only entries below len_q are ever used
  always_ff @(posedge clk_i) begin
    if (ctl_i.append && !ctl_i.clear && !full) begin
      pat_q[len_q[IW-1:0]] <= ctl_i.code;
    end
  end

  assign str_fold = fold(str_code_i, ignore_case_i);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic vld, is_star, is_q;
    assign vld            = (LW'(i) < len_q);
    assign is_star        = (pat_q[i] == CODE_STAR);
    assign is_q           = (pat_q[i] == CODE_QMARK);
    assign star_mask_o[i] = vld && is_star;
    assign hit_mask_o[i]  = vld && !is_star &&
                            (is_q || (fold(pat_q[i], ignore_case_i) == str_fold));
  end

  assign len_o      = len_q;
  assign full_o     = full;
  assign overflow_o = ovf_q;

endmodule
`default_nettype wire

@@ rtl/wpm_nfa.sv @@
`default_nettype none
module wpm_nfa
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32,
  parameter int unsigned LW = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire nfa_ctl_t               ctl_i,
  input  wire logic [PATTERN_MAX-1:0] star_mask_i,
  input  wire logic [PATTERN_MAX-1:0] hit_mask_i,
  input  wire logic [LW-1:0]          len_i,
  output logic                        final_hit_o
);

  localparam int unsigned SW = PATTERN_MAX + 1;

  logic [SW-1:0] act_q, act_d;
  logic [SW-1:0] star_ext, gen, carry, closed, next_set;

  // Star closure as a carry chain: a set bit on a star carries into the next
  // position and keeps rippling through a run of stars.
  assign star_ext = {1'b0, star_mask_i};
  assign gen      = act_q & star_ext;
  assign carry    = (star_ext + gen) ^ star_ext ^ gen;
  assign closed   = act_q | carry;

  // Star stays put, literal or '?' moves one position up
  assign next_set = (closed & star_ext) | {closed[PATTERN_MAX-1:0] & hit_mask_i, 1'b0};

  always_comb begin
    act_d = act_q;
    if (ctl_i.rearm) begin
      act_d = SW'(1);
    end else if (ctl_i.str_step) begin
      act_d = next_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= SW'(1);
    end else begin
      act_q <= act_d;
    end
  end

  assign final_hit_o = closed[len_i];

endmodule
`default_nettype wire

@@ rtl/wildcard_pattern_matcher_top.sv @@
`default_nettype none
// Wildcard pattern matcher: glob match of a streamed string against a stored
// pattern ('*' any run, '?' any one character).
// Channels: req_i (sink) carries command and char_code; rsp_o (source) carries
// matched and pattern_overflow, one response per end-of-string request only.
// Commands: clear pattern, append pattern char, string char, end of string.
// Code zero on append or string char is dropped with no effect.
// Config: APB-style port, register 0 (byte addr 0) is ignore_case; pready is
// tied high, writes land on the access cycle.
// Pipeline: an input register, then one pass through pattern compare, star
// closure (one carry chain of PATTERN_MAX+1 bits) and NFA update into the
// active-set and response registers.
// Order: an accepted end-of-string request passes through the input register,
// then loads the response register, which drives the response handshake.
// Throughput: one request per cycle, any mix of commands, unless stalled.
// Stall: a held response stalls the input only while an end-of-string request
// waits behind it in the input register; other requests keep flowing.
// Reset: empty pattern, no overflow, active set at position zero, ignore_case
// 0, no response pending. The pattern entries have no reset and need no pass.
module wildcard_pattern_matcher_top
  import wpm_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  wpm_req_if.sink                req_i,
  wpm_rsp_if.source              rsp_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned LW = $clog2(PATTERN_MAX + 1);

  // Input register
  logic     s1_vld_q, s1_vld_d;
  req_t     s1_req_q;
  logic     s1_fire, in_ready, is_end;

  // Response register
  logic     out_vld_q, out_vld_d;
  rsp_t     out_q;

  logic                   ignore_case;
  logic [LW-1:0]          pat_len;
  logic                   pat_full, pat_ovf, fin_hit;
  logic [PATTERN_MAX-1:0] star_mask, hit_mask;
  pat_ctl_t               pat_ctl;
  nfa_ctl_t               nfa_ctl;
  logic                   code_nz;

  wpm_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ignore_case_o(ignore_case)
  );

  // Only an end-of-string request needs a free response slot
  assign is_end   = (s1_req_q.command == CMD_END);
  assign s1_fire  = s1_vld_q && (!is_end || !out_vld_q || rsp_o.ready);
  assign in_ready = !s1_vld_q || s1_fire;
  assign req_i.ready = in_ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_ready) begin
      s1_vld_d = req_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      s1_req_q <= '{command: cmd_e'(req_i.command), char_code: req_i.char_code};
    end
  end

  // Decode the request in the input register
  assign code_nz = (s1_req_q.char_code != '0);

  always_comb begin
    pat_ctl.clear  = s1_fire && (s1_req_q.command == CMD_CLEAR);
    pat_ctl.append = s1_fire && (s1_req_q.command == CMD_APPEND) && code_nz;
    pat_ctl.code   = s1_req_q.char_code;
    // clear, a stored append and end of string all restart the set
    nfa_ctl.rearm    = pat_ctl.clear || (pat_ctl.append && !pat_full) ||
                       (s1_fire && is_end);
    nfa_ctl.str_step = s1_fire && (s1_req_q.command == CMD_STRING) && code_nz;
  end

  wpm_pattern_store #(
    .PATTERN_MAX(PATTERN_MAX),
    .LW         (LW)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (pat_ctl),
    .str_code_i   (s1_req_q.char_code),
    .ignore_case_i(ignore_case),
    .len_o        (pat_len),
    .full_o       (pat_full),
    .overflow_o   (pat_ovf),
    .star_mask_o  (star_mask),
    .hit_mask_o   (hit_mask)
  );

  wpm_nfa #(
    .PATTERN_MAX(PATTERN_MAX),
    .LW         (LW)
  ) u_nfa (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (nfa_ctl),
    .star_mask_i(star_mask),
    .hit_mask_i (hit_mask),
    .len_i      (pat_len),
    .final_hit_o(fin_hit)
  );

  // Response register
  always_comb begin
    out_vld_d = out_vld_q;
    if (s1_fire && is_end) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && is_end) begin
      out_q.matched          <= fin_hit && !pat_ovf;
      out_q.pattern_overflow <= pat_ovf;
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.matched          = out_q.matched;
  assign rsp_o.pattern_overflow = out_q.pattern_overflow;

  // Checks
  a_no_match_on_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.matched && out_q.pattern_overflow))
    else $error("match reported with overflowed pattern");

  a_clear_drops_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_ctl.clear |=> (!pat_ovf && (pat_len == '0)))
    else $error("clear did not empty the pattern");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_len <= LW'(PATTERN_MAX))
    else $error("pattern length beyond capacity");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_vld_q && is_end && out_vld_q && !rsp_o.ready))
    else $error("input stalled without a blocked response");

endmodule
`default_nettype wire
